### rtl/easing_curve_evaluator_assert.svh
// assertion macros used by the top-level rtl file
`ifndef EASING_CURVE_EVALUATOR_ASSERT_SVH
`define EASING_CURVE_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define ECE_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("easing curve evaluator check failed");

// next-cycle implication
`define ECE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("easing curve evaluator check failed");

`endif

### rtl/ece_pkg.sv
`timescale 1ns / 1ps
package ece_pkg;

  localparam int QB = 30;
  localparam logic [31:0] QONE = 32'd1 << QB;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [31:0] SB1 = 32'd1686629713;
  localparam logic [31:0] SB3 = 32'd693598668;
  localparam logic [31:0] SB5 = 32'd85569306;
  localparam logic [31:0] SB7 = 32'd5026995;
  localparam logic [31:0] SB9 = 32'd172272;
  localparam logic [31:0] SB11 = 32'd3864;
  localparam logic [31:0] BACK_C1 = 32'd1827057613;
  localparam logic [31:0] BACK_C3 = 32'd2900799437;

  localparam logic [4:0] MODE_IN_FIRST = 5'd1;
  localparam logic [4:0] MODE_OUT_FIRST = 5'd10;
  localparam logic [4:0] MODE_INOUT_FIRST = 5'd19;
  localparam logic [4:0] MODE_INOUT_BOUNCE = 5'd26;

  localparam int SQRT_STEPS = 32;
  localparam int EXPO_LAT = QB + 2;
  localparam int EASE_LAT = SQRT_STEPS + 3;

  typedef enum logic [3:0] {
    FAM_SINE, FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT,
    FAM_EXPO, FAM_CIRC, FAM_BACK, FAM_BOUNCE, FAM_LINEAR
  } fam_t;

  typedef enum logic [1:0] {KIND_DIRECT, KIND_OUT, KIND_LO, KIND_HI} kind_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_st_t;

  typedef logic [31:0] coef_arr_t [QB+1];

  function automatic logic [31:0] mulq(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + (64'd1 << (QB - 1));
    return p[QB+31:QB];
  endfunction

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [63:0] bitv);
    sqrt_st_t o;
    if (s.rem >= s.root + bitv) begin
      o.rem = s.rem - (s.root + bitv);
      o.root = (s.root >> 1) + bitv;
    end else begin
      o.rem = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  function automatic logic [63:0] step_bit(input int i);
    return 64'd1 << (62 - 2 * i);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    sqrt_st_t s;
    s.rem = v;
    s.root = 64'd0;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      s = sqrt_step(s, step_bit(i));
    end
    return s.root;
  endfunction

  // c[k] = 2^(-2^-k), each a floor square root of the one before
  function automatic coef_arr_t expo_coefs();
    coef_arr_t c;
    logic [63:0] w;
    w = 64'(QONE >> 1);
    c[0] = w[31:0];
    for (int k = 1; k <= QB; k++) begin
      w = isqrt64(w << QB);
      c[k] = w[31:0];
    end
    return c;
  endfunction

endpackage

### rtl/ece_sqrt.sv
`timescale 1ns / 1ps
module ece_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] vin,
  output logic [31:0] root_o
);

  ece_pkg::sqrt_st_t st_r   [ece_pkg::SQRT_STEPS];
  ece_pkg::sqrt_st_t st_nxt [ece_pkg::SQRT_STEPS];
  ece_pkg::sqrt_st_t st_in;

  always_comb begin
    st_in.rem = vin;
    st_in.root = 64'd0;
    st_nxt[0] = ece_pkg::sqrt_step(st_in, ece_pkg::step_bit(0));
    for (int i = 1; i < ece_pkg::SQRT_STEPS; i++) begin
      st_nxt[i] = ece_pkg::sqrt_step(st_r[i-1], ece_pkg::step_bit(i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < ece_pkg::SQRT_STEPS; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign root_o = st_r[ece_pkg::SQRT_STEPS-1].root[31:0];

endmodule

### rtl/ece_expo.sv
`timescale 1ns / 1ps
module ece_expo (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] u_i,
  output logic [31:0] y_o
);

  localparam int QB = ece_pkg::QB;
  localparam ece_pkg::coef_arr_t CK = ece_pkg::expo_coefs();

  logic [33:0] xs_r  [QB+1];
  logic        zs_r  [QB+1];
  logic [31:0] acc_r [QB+1];
  logic [31:0] y_r;
  logic [3:0]  n_w;
  logic [31:0] rnd_w;

  // 10 * (1 - u), then one factor per fraction bit
  always_ff @(posedge clk) begin
    if (en) begin
      xs_r[0] <= 34'(ece_pkg::QONE - u_i) * 34'd10;
      zs_r[0] <= (u_i == 32'd0);
      acc_r[0] <= ece_pkg::QONE;
      for (int k = 1; k <= QB; k++) begin
        xs_r[k] <= xs_r[k-1];
        zs_r[k] <= zs_r[k-1];
        acc_r[k] <= xs_r[k-1][QB-k] ? ece_pkg::mulq(acc_r[k-1], CK[k]) : acc_r[k-1];
      end
      y_r <= zs_r[QB] ? 32'd0 : (acc_r[QB] + rnd_w) >> n_w;
    end
  end

  assign n_w = xs_r[QB][QB+3:QB];
  assign rnd_w = (32'd1 << n_w) >> 1;
  assign y_o = y_r;

endmodule

### rtl/ece_ease.sv
`timescale 1ns / 1ps
module ece_ease (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         u_i,
  input  ece_pkg::fam_t       fam_i,
  output logic [31:0]         ease_o
);

  localparam int LAT = ece_pkg::EASE_LAT;
  localparam int LAT_QUAD = 1;
  localparam int LAT_CUBIC = 2;
  localparam int LAT_QUART = 3;
  localparam int LAT_BOUNCE = 3;
  localparam int LAT_QUINT = 4;
  localparam int LAT_BACK = 4;
  localparam int LAT_SINE = 7;
  localparam int LAT_EXPO = ece_pkg::EXPO_LAT;
  localparam int LAT_CIRC = ece_pkg::SQRT_STEPS + 2;
  localparam logic [31:0] QONE = ece_pkg::QONE;
  localparam logic [31:0] SIN_COEF [5] = '{ece_pkg::SB9, ece_pkg::SB7, ece_pkg::SB5,
                                           ece_pkg::SB3, ece_pkg::SB1};
  localparam logic [34:0] E4 = 35'(QONE) * 35'd4;
  localparam logic [34:0] E6 = 35'(QONE) * 35'd6;
  localparam logic [34:0] E8 = 35'(QONE) * 35'd8;
  localparam logic [34:0] E9 = 35'(QONE) * 35'd9;
  localparam logic [34:0] E10 = 35'(QONE) * 35'd10;
  localparam logic [34:0] E105 = 35'(QONE >> 1) * 35'd21;

  // powers and back
  logic [31:0] ud_r [1:3];
  logic [31:0] u2_r, u3_r, u4_r, u5_r, u2d_r, bm3_r, bm1_r, back_r;
  // sine
  logic [31:0] sx_r [1:6];
  logic [31:0] sx2_r [1:5];
  logic [31:0] sp_r [2:6];
  logic [31:0] sp_nxt [2:6];
  logic [31:0] sin_x, sin_q, sin_r;
  // bounce
  logic [31:0] bv, bd_nxt, bb_nxt, bd_r, bb_r, bb2_r, sq_w, bnc_r;
  logic [34:0] be, bk;
  logic [63:0] bs_r;
  // circ and expo
  logic [31:0] root_w, circ_r, expo_w;
  // result merge
  logic [31:0]   res_r [1:LAT];
  ece_pkg::fam_t fam_r [1:LAT-1];
  logic [31:0]   pick  [1:LAT-1];

  ece_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .vin    (64'(QONE - u2_r) << ece_pkg::QB),
    .root_o (root_w)
  );

  ece_expo u_expo (
    .clk (clk),
    .en  (en),
    .u_i (u_i),
    .y_o (expo_w)
  );

  always_comb begin
    sin_x = QONE - u_i;
    sp_nxt[2] = SIN_COEF[0] - ece_pkg::mulq(sx2_r[1], ece_pkg::SB11);
    for (int j = 3; j <= 6; j++) begin
      sp_nxt[j] = SIN_COEF[j-2] - ece_pkg::mulq(sx2_r[j-1], sp_r[j-1]);
    end
    sin_q = ece_pkg::mulq(sx_r[6], sp_r[6]);
  end

  always_comb begin
    bv = QONE - u_i;
    be = 35'(bv) * 35'd11;
    bk = 35'd0;
    bb_nxt = 32'd0;
    if (be < E4) begin
      bk = 35'd0;
      bb_nxt = 32'd0;
    end else if (be < E8) begin
      bk = E6;
      bb_nxt = 32'd3 << 28;
    end else if (be < E10) begin
      bk = E9;
      bb_nxt = 32'd15 << 26;
    end else begin
      bk = E105;
      bb_nxt = 32'd63 << 24;
    end
    bd_nxt = (be >= bk) ? 32'(be - bk) : 32'(bk - be);
    sq_w = 32'(({1'b0, bs_r[63:33]} + 32'd1) >> 1);
  end

  always_comb begin
    for (int j = 1; j < LAT; j++) begin
      pick[j] = res_r[j];
    end
    if (fam_r[LAT_QUAD] == ece_pkg::FAM_QUAD) pick[LAT_QUAD] = u2_r;
    if (fam_r[LAT_CUBIC] == ece_pkg::FAM_CUBIC) pick[LAT_CUBIC] = u3_r;
    if (fam_r[LAT_QUART] == ece_pkg::FAM_QUART) pick[LAT_QUART] = u4_r;
    if (fam_r[LAT_BOUNCE] == ece_pkg::FAM_BOUNCE) pick[LAT_BOUNCE] = bnc_r;
    if (fam_r[LAT_QUINT] == ece_pkg::FAM_QUINT) pick[LAT_QUINT] = u5_r;
    if (fam_r[LAT_BACK] == ece_pkg::FAM_BACK) pick[LAT_BACK] = back_r;
    if (fam_r[LAT_SINE] == ece_pkg::FAM_SINE) pick[LAT_SINE] = sin_r;
    if (fam_r[LAT_EXPO] == ece_pkg::FAM_EXPO) pick[LAT_EXPO] = expo_w;
    if (fam_r[LAT_CIRC] == ece_pkg::FAM_CIRC) pick[LAT_CIRC] = circ_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ud_r[1] <= u_i;
      ud_r[2] <= ud_r[1];
      ud_r[3] <= ud_r[2];
      u2_r <= ece_pkg::mulq(u_i, u_i);
      u3_r <= ece_pkg::mulq(u2_r, ud_r[1]);
      u4_r <= ece_pkg::mulq(u3_r, ud_r[2]);
      u5_r <= ece_pkg::mulq(u4_r, ud_r[3]);
      u2d_r <= u2_r;
      bm3_r <= ece_pkg::mulq(ece_pkg::BACK_C3, u3_r);
      bm1_r <= ece_pkg::mulq(ece_pkg::BACK_C1, u2d_r);
      back_r <= bm3_r - bm1_r;

      sx_r[1] <= sin_x;
      sx2_r[1] <= ece_pkg::mulq(sin_x, sin_x);
      for (int j = 2; j <= 6; j++) begin
        sx_r[j] <= sx_r[j-1];
        sp_r[j] <= sp_nxt[j];
      end
      for (int j = 2; j <= 5; j++) begin
        sx2_r[j] <= sx2_r[j-1];
      end
      sin_r <= QONE - ((sin_q > QONE) ? QONE : sin_q);

      bd_r <= bd_nxt;
      bb_r <= bb_nxt;
      bs_r <= 64'(bd_r) * 64'(bd_r);
      bb2_r <= bb_r;
      bnc_r <= QONE - (bb2_r + sq_w);

      circ_r <= QONE - root_w;

      res_r[1] <= u_i;
      fam_r[1] <= fam_i;
      for (int j = 2; j < LAT; j++) begin
        res_r[j] <= pick[j-1];
        fam_r[j] <= fam_r[j-1];
      end
      res_r[LAT] <= pick[LAT-1];
    end
  end

  assign ease_o = res_r[LAT];

endmodule

### rtl/easing_curve_evaluator.sv
`timescale 1ns / 1ps
// easing curve evaluator
// input stream: in_tuser carries the curve selector, in_tdata the progress t
// (unsigned, FRACTION_BITS fraction bits, saturated at 1.0). output stream:
// out_tdata carries the eased value, signed, FRACTION_BITS fraction bits.
// the block is a pipeline through the input, easing, fix-up and rounding
// registers; one transaction per cycle is taken and given sustained while
// the output buffer has room. the depth is set by the bit-per-stage square
// root of the circ curves (32 stages); the expo factor chain is shorter.
// a two-entry output buffer sits after the pipeline; the whole pipeline
// advances while that buffer has room, so a stalled receiver freezes the
// pipeline only once both entries are full, and in_tready drops then.
// nothing in flight is lost or repeated across a stall.
// reset (rst_n low, synchronous) empties the pipeline and the buffer; no
// clearing pass follows, in_tready is high in the first cycle after reset.
`include "easing_curve_evaluator_assert.svh"
module easing_curve_evaluator #(
  parameter int FRACTION_BITS = ece_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] progress
  input  logic [4:0]  in_tuser,   // [4:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [17:0] eased
);

  localparam int LAT = ece_pkg::EASE_LAT;
  localparam int NSTG = LAT + 3;
  localparam int SH = ece_pkg::QB - FRACTION_BITS;
  localparam logic [31:0] QONE = ece_pkg::QONE;
  localparam logic signed [33:0] QONE_S = 34'(ece_pkg::QONE);
  localparam logic signed [33:0] RND_C = 34'(1) << (SH - 1);

  logic en, push, pop;
  logic [NSTG-1:0] vld_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [17:0] q0_r, q1_r;

  logic [31:0] t_ext, one_w, t_sat, t30;
  logic [4:0] mode;
  logic [31:0] u_nxt, u1_r;
  ece_pkg::fam_t fam_nxt, fam1_r;
  ece_pkg::kind_t kind_nxt, kind1_r;
  ece_pkg::kind_t kd_r [LAT];

  logic [31:0] ease_w;
  logic signed [33:0] e_s, half_s, v_nxt, v_r, rnd_s;
  logic [17:0] eased_r;

  assign en = (cnt_r != 2'd2);
  assign in_tready = en;
  assign pop = out_tvalid && out_tready;
  assign push = en && vld_r[NSTG-1];

  always_comb begin
    t_ext = {15'd0, in_tdata[16:0]};
    one_w = 32'd1 << FRACTION_BITS;
    t_sat = (t_ext > one_w) ? one_w : t_ext;
    t30 = t_sat << SH;
    mode = in_tuser;
    u_nxt = t30;
    fam_nxt = ece_pkg::FAM_LINEAR;
    kind_nxt = ece_pkg::KIND_DIRECT;
    if (mode >= ece_pkg::MODE_IN_FIRST && mode < ece_pkg::MODE_OUT_FIRST) begin
      fam_nxt = ece_pkg::fam_t'(4'(mode - ece_pkg::MODE_IN_FIRST));
    end else if (mode >= ece_pkg::MODE_OUT_FIRST && mode < ece_pkg::MODE_INOUT_FIRST) begin
      fam_nxt = ece_pkg::fam_t'(4'(mode - ece_pkg::MODE_OUT_FIRST));
      kind_nxt = ece_pkg::KIND_OUT;
      u_nxt = QONE - t30;
    end else if (mode >= ece_pkg::MODE_INOUT_FIRST && mode <= ece_pkg::MODE_INOUT_BOUNCE) begin
      fam_nxt = (mode == ece_pkg::MODE_INOUT_BOUNCE) ? ece_pkg::FAM_BOUNCE :
                ece_pkg::fam_t'(4'(mode - ece_pkg::MODE_INOUT_FIRST));
      if (t30 < (QONE >> 1)) begin
        kind_nxt = ece_pkg::KIND_LO;
        u_nxt = t30 << 1;
      end else begin
        kind_nxt = ece_pkg::KIND_HI;
        u_nxt = (QONE << 1) - (t30 << 1);
      end
    end
  end

  ece_ease u_ease (
    .clk    (clk),
    .en     (en),
    .u_i    (u1_r),
    .fam_i  (fam1_r),
    .ease_o (ease_w)
  );

  always_comb begin
    e_s = 34'(signed'(ease_w));
    half_s = (e_s + 34'sd1) >>> 1;
    case (kd_r[LAT-1])
      ece_pkg::KIND_DIRECT: v_nxt = e_s;
      ece_pkg::KIND_OUT:    v_nxt = QONE_S - e_s;
      ece_pkg::KIND_LO:     v_nxt = half_s;
      ece_pkg::KIND_HI:     v_nxt = QONE_S - half_s;
      default:              v_nxt = e_s;
    endcase
    rnd_s = (v_r + RND_C) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r <= u_nxt;
      fam1_r <= fam_nxt;
      kind1_r <= kind_nxt;
      kd_r[0] <= kind1_r;
      for (int i = 1; i < LAT; i++) begin
        kd_r[i] <= kd_r[i-1];
      end
      v_r <= v_nxt;
      eased_r <= rnd_s[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // two-entry output buffer
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) begin
      q0_r <= eased_r;
    end else if (pop) begin
      q0_r <= q1_r;
    end
    if (push && !(cnt_r == 2'd0 || (cnt_r == 2'd1 && pop))) begin
      q1_r <= eased_r;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata = {6'd0, q0_r};

  `ECE_ASSERT(a_cnt_bound, 1'b1, cnt_r != 2'd3)
  `ECE_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_r))
  `ECE_ASSERT_NEXT(a_push_count, push && !pop, cnt_r == $past(cnt_r) + 2'd1)
  `ECE_ASSERT_NEXT(a_pop_count, pop && !push, cnt_r == $past(cnt_r) - 2'd1)

endmodule

### tb/easing_curve_evaluator_tb.sv
`timescale 1ns / 1ps
module easing_curve_evaluator_tb;

  typedef bit [63:0] u64;

  localparam u64 Q1 = 64'd1 << 30;
  localparam int FB = 16;
  localparam logic [4:0] MODE_LINEAR = 5'd0;
  localparam logic [4:0] MODE_IN_SINE = ece_pkg::MODE_IN_FIRST;
  localparam logic [4:0] MODE_IN_QUINT = ece_pkg::MODE_IN_FIRST + 5'd4;
  localparam logic [4:0] MODE_IN_EXPO = ece_pkg::MODE_IN_FIRST + 5'd5;
  localparam logic [4:0] MODE_IN_BACK = ece_pkg::MODE_IN_FIRST + 5'd7;
  localparam logic [4:0] MODE_IN_BOUNCE = ece_pkg::MODE_IN_FIRST + 5'd8;
  localparam logic [4:0] MODE_OUT_QUAD = ece_pkg::MODE_OUT_FIRST + 5'd1;
  localparam logic [4:0] MODE_OUT_EXPO = ece_pkg::MODE_OUT_FIRST + 5'd5;
  localparam logic [4:0] MODE_OUT_CIRC = ece_pkg::MODE_OUT_FIRST + 5'd6;
  localparam logic [4:0] MODE_OUT_BACK = ece_pkg::MODE_OUT_FIRST + 5'd7;
  localparam logic [4:0] MODE_INOUT_QUAD = ece_pkg::MODE_INOUT_FIRST + 5'd1;
  localparam logic [4:0] MODE_INOUT_EXPO = ece_pkg::MODE_INOUT_FIRST + 5'd5;
  localparam logic [4:0] MODE_INOUT_CIRC = ece_pkg::MODE_INOUT_FIRST + 5'd6;
  localparam logic [4:0] MODE_OFF_LIST_LO = 5'd27;
  localparam logic [4:0] MODE_OFF_LIST_HI = 5'd31;
  localparam int N_RANDOM = 750;
  localparam int QUIET_FROM = 640;
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [4:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;

  logic [17:0] pending_eased[$];
  u64 expo_c[31];
  bit gaps_on = 1'b1;
  bit failed = 1'b0;
  int n_sent = 0;
  int quiet_cycles = 0;

  typedef struct {
    logic [4:0] mode;
    logic [16:0] progress;
    bit typed;
    logic [17:0] eased;
  } vec_t;

  easing_curve_evaluator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  function automatic u64 q_mul(u64 a, u64 b);
    return (a * b + (Q1 >> 1)) >> 30;
  endfunction

  function automatic u64 root_floor(u64 v);
    u64 r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic u64 sine_quarter_wave(u64 x);
    u64 x2, p;
    x2 = q_mul(x, x);
    p = u64'(ece_pkg::SB9) - q_mul(x2, ece_pkg::SB11);
    p = u64'(ece_pkg::SB7) - q_mul(x2, p);
    p = u64'(ece_pkg::SB5) - q_mul(x2, p);
    p = u64'(ece_pkg::SB3) - q_mul(x2, p);
    p = u64'(ece_pkg::SB1) - q_mul(x2, p);
    p = q_mul(x, p);
    return p > Q1 ? Q1 : p;
  endfunction

  function automatic u64 exp2_neg(u64 x);
    u64 n, acc;
    n = x >> 30;
    acc = Q1;
    for (int k = 1; k <= 30; k++) begin
      if ((x >> (30 - k)) & 64'd1) acc = q_mul(acc, expo_c[k]);
    end
    if (n == 0) return acc;
    if (n > 40) return 0;
    return (acc + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic u64 raise(u64 u, int n);
    u64 r;
    r = u;
    for (int i = 1; i < n; i++) r = q_mul(r, u);
    return r;
  endfunction

  function automatic u64 bounce_tail(u64 u);
    u64 e, d, base, k;
    e = 11 * u;
    k = 21 * (Q1 >> 1);
    if (e < 4 * Q1) begin
      d = e;
      base = 0;
    end else if (e < 8 * Q1) begin
      d = e >= 6 * Q1 ? e - 6 * Q1 : 6 * Q1 - e;
      base = u64'(3) << 28;
    end else if (e < 10 * Q1) begin
      d = e >= 9 * Q1 ? e - 9 * Q1 : 9 * Q1 - e;
      base = u64'(15) << 26;
    end else begin
      d = e >= k ? e - k : k - e;
      base = u64'(63) << 24;
    end
    return base + ((((d * d) >> 33) + 1) >> 1);
  endfunction

  function automatic longint curve_in(ece_pkg::fam_t fam, u64 u);
    case (fam)
      ece_pkg::FAM_SINE: return longint'(Q1 - sine_quarter_wave(Q1 - u));
      ece_pkg::FAM_QUAD, ece_pkg::FAM_CUBIC, ece_pkg::FAM_QUART, ece_pkg::FAM_QUINT:
        return longint'(raise(u, int'(fam) + 1));
      ece_pkg::FAM_EXPO: begin
        if (u == 0) return 0;
        return longint'(exp2_neg(10 * (Q1 - u)));
      end
      ece_pkg::FAM_CIRC: return longint'(Q1 - root_floor((Q1 - q_mul(u, u)) << 30));
      ece_pkg::FAM_BACK: return longint'(q_mul(ece_pkg::BACK_C3, raise(u, 3))) -
                                longint'(q_mul(ece_pkg::BACK_C1, raise(u, 2)));
      default: return longint'(Q1 - bounce_tail(Q1 - u));
    endcase
  endfunction

  function automatic longint half_round(longint v);
    u64 b;
    b = u64'(v + (longint'(1) << 33));
    return longint'((b + 1) >> 1) - (longint'(1) << 32);
  endfunction

  function automatic logic [17:0] eased_value(logic [4:0] mode, logic [16:0] progress);
    u64 t, t30;
    longint v, r, bias;
    ece_pkg::fam_t fam;
    bias = longint'(1) << 32;
    t = progress > 17'h10000 ? 64'h10000 : u64'(progress);
    t30 = t << (30 - FB);
    if (mode >= ece_pkg::MODE_IN_FIRST && mode < ece_pkg::MODE_OUT_FIRST) begin
      v = curve_in(ece_pkg::fam_t'(4'(mode - ece_pkg::MODE_IN_FIRST)), t30);
    end else if (mode >= ece_pkg::MODE_OUT_FIRST && mode < ece_pkg::MODE_INOUT_FIRST) begin
      v = longint'(Q1) - curve_in(ece_pkg::fam_t'(4'(mode - ece_pkg::MODE_OUT_FIRST)),
                                  Q1 - t30);
    end else if (mode >= ece_pkg::MODE_INOUT_FIRST && mode <= ece_pkg::MODE_INOUT_BOUNCE) begin
      fam = mode == ece_pkg::MODE_INOUT_BOUNCE ? ece_pkg::FAM_BOUNCE :
            ece_pkg::fam_t'(4'(mode - ece_pkg::MODE_INOUT_FIRST));
      if (t30 < (Q1 >> 1)) v = half_round(curve_in(fam, 2 * t30));
      else v = longint'(Q1) - half_round(curve_in(fam, 2 * Q1 - 2 * t30));
    end else begin
      v = longint'(t30);
    end
    r = longint'((u64'(v + bias) + (64'd1 << (29 - FB))) >> (30 - FB)) - (bias >>> (30 - FB));
    return r[17:0];
  endfunction

  task automatic send(logic [4:0] mode, logic [16:0] progress, logic [17:0] eased);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {7'd0, progress};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_eased.push_back(eased);
    n_sent++;
  endtask

  // result checking
  always @(posedge clk) begin
    logic [17:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_eased.size() == 0) begin
        $error("unexpected transaction eased=%0d", $signed(out_tdata[17:0]));
        failed = 1'b1;
      end else begin
        want = pending_eased.pop_front();
        if (out_tdata[17:0] !== want) begin
          $error("eased: expected %0d actual %0d", $signed(want), $signed(out_tdata[17:0]));
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready))) quiet_cycles++;
    else quiet_cycles = 0;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("easing_curve_evaluator: mismatch");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    bit held;
    held = 1'b0;
    repeat (6) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!held && n_sent >= 150) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        out_tready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_tready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    vec_t vecs[$];
    logic [4:0] m;
    logic [16:0] p;
    u64 c;
    c = Q1 >> 1;
    expo_c[0] = c;
    for (int k = 1; k <= 30; k++) begin
      c = root_floor(c << 30);
      expo_c[k] = c;
    end
    vecs = '{
      '{MODE_LINEAR, 17'd0, 1'b1, 18'd0},
      '{MODE_LINEAR, 17'd65536, 1'b1, 18'd65536},
      '{MODE_LINEAR, 17'd131071, 1'b1, 18'd65536},
      '{MODE_OFF_LIST_HI, 17'd12345, 1'b1, 18'd12345},
      '{MODE_OFF_LIST_LO, 17'd100000, 1'b1, 18'd65536},
      '{MODE_IN_EXPO, 17'd0, 1'b1, 18'd0},
      '{MODE_OUT_EXPO, 17'd65536, 1'b1, 18'd65536},
      '{MODE_INOUT_EXPO, 17'd0, 1'b1, 18'd0},
      '{MODE_INOUT_EXPO, 17'd65536, 1'b1, 18'd65536},
      '{MODE_INOUT_EXPO, 17'd32768, 1'b0, 18'd0},
      '{MODE_INOUT_QUAD, 17'd32768, 1'b0, 18'd0},
      '{ece_pkg::MODE_INOUT_BOUNCE, 17'd32768, 1'b0, 18'd0},
      '{MODE_INOUT_CIRC, 17'd32767, 1'b0, 18'd0},
      '{MODE_IN_BACK, 17'd20000, 1'b0, 18'd0},
      '{MODE_OUT_BACK, 17'd45000, 1'b0, 18'd0},
      '{MODE_IN_SINE, 17'd65536, 1'b0, 18'd0},
      '{MODE_IN_SINE, 17'd1, 1'b0, 18'd0},
      '{MODE_OUT_CIRC, 17'd1, 1'b0, 18'd0},
      '{MODE_IN_BOUNCE, 17'd65535, 1'b0, 18'd0},
      '{MODE_IN_QUINT, 17'd131071, 1'b0, 18'd0},
      '{MODE_OUT_QUAD, 17'd0, 1'b0, 18'd0},
      '{MODE_IN_EXPO, 17'd1, 1'b0, 18'd0}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (vecs[i]) begin
      send(vecs[i].mode, vecs[i].progress,
           vecs[i].typed ? vecs[i].eased : eased_value(vecs[i].mode, vecs[i].progress));
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == QUIET_FROM) gaps_on = 1'b0;
      m = 5'($urandom_range(0, 31));
      p = $urandom_range(0, 9) < 7 ? 17'($urandom_range(0, 65536)) : 17'($urandom_range(0, 131071));
      send(m, p, eased_value(m, p));
    end
    in_tvalid <= 1'b0;
    while (pending_eased.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("easing_curve_evaluator: match");
    end else begin
      $display("easing_curve_evaluator: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ece_pkg.sv
rtl/ece_sqrt.sv
rtl/ece_expo.sv
rtl/ece_ease.sv
rtl/easing_curve_evaluator.sv
tb/easing_curve_evaluator_tb.sv
